// ----- rtl/assert_macros.svh -----
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/twg_pkg.sv -----
// shared types, constants and table functions of the tone generator
`timescale 1ns / 1ps

package twg_pkg;

	// default sizes
	localparam int SINE_TABLE_BITS_DEF = 10;
	localparam int INDEX_BITS_DEF      = 20;

	// register port
	localparam int ADDR_W = 5;
	localparam int REG_W  = 3;
	localparam int DATA_W = 32;

	localparam logic [REG_W-1:0] REG_ENABLE       = 3'd0;
	localparam logic [REG_W-1:0] REG_PHASE_STEP   = 3'd1;
	localparam int               REG_WAVE_KIND_I  = 2;
	localparam logic [REG_W-1:0] REG_WAVE_KIND    = 3'd2;
	localparam logic [REG_W-1:0] REG_TONE_LEVEL   = 3'd3;
	localparam logic [REG_W-1:0] REG_MASTER_LEVEL = 3'd4;
	localparam logic [REG_W-1:0] REG_TONE_LENGTH  = 3'd5;
	localparam logic [REG_W-1:0] REG_FADE_LENGTH  = 3'd6;

	// field widths
	localparam int TONE_LEN_W = 20;
	localparam int FADE_W     = 16;
	localparam int LEVEL_W    = 9;
	localparam int MAG_W      = 15;
	localparam int SAMPLE_W   = 16;

	// waveform codes
	localparam logic [1:0] WAVE_SINE   = 2'd0;
	localparam logic [1:0] WAVE_SQUARE = 2'd1;
	localparam logic [1:0] WAVE_SAW    = 2'd2;
	localparam logic [1:0] WAVE_NOISE  = 2'd3;

	// reset values
	localparam logic [31:0]           PHASE_STEP_RST   = 32'd42852281;
	localparam logic [LEVEL_W-1:0]    TONE_LEVEL_RST   = 9'd77;
	localparam logic [LEVEL_W-1:0]    MASTER_LEVEL_RST = 9'd256;
	localparam logic [LEVEL_W-1:0]    FULL_LEVEL       = 9'd256;
	localparam logic [TONE_LEN_W-1:0] TONE_LENGTH_RST  = 20'd2205;
	localparam logic [FADE_W-1:0]     FADE_LENGTH_RST  = 16'd441;

	// noise generator
	localparam logic [15:0] NOISE_SEED = 16'hACE1;
	localparam logic [15:0] NOISE_TAPS = 16'hB400;

	// full-scale magnitude
	localparam logic [MAG_W-1:0] FULL_SCALE = 15'd32767;

	// divider steps, one quotient bit each
	localparam int DIV_STEPS = 16;

	// sine table generation, elaboration only
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned TAYLOR_DIV [6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
		64'd156};

	typedef struct packed {
		logic                  enable;
		logic [31:0]           phase_step;
		logic [1:0]            wave_kind;
		logic [LEVEL_W-1:0]    tone_level;
		logic [LEVEL_W-1:0]    master_level;
		logic [TONE_LEN_W-1:0] tone_length;
		logic [FADE_W-1:0]     fade_length;
	} cfg_t;

	typedef struct packed {
		logic [31:0] mul_a;
		logic [16:0] mul_b;
		logic [15:0] rem;
		logic        dbit;
		logic [15:0] den;
	} mdu_in_t;

	typedef struct packed {
		logic [48:0] prod;
		logic [15:0] rem;
		logic        qbit;
	} mdu_out_t;

	// round(32767 * sin(pi/2 * r / quarter)) from a degree-13 series in q30
	function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned r,
		input int unsigned tb);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned v;
		longint          sum;
		x = (HALF_PI_Q30 * longint'(r)) >> (tb - 2);
		x2 = (x * x) >> 30;
		term = x;
		sum = longint'(x);
		for (int n = 1; n <= 6; n++) begin
			term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
			if (n % 2 == 1)
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		if (sum < 0)
			sum = 0;
		v = (longint'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
		if (v > 64'd32767)
			v = 64'd32767;
		return MAG_W'(v);
	endfunction

	// one step of the galois noise register
	function automatic logic [15:0] noise_step(input logic [15:0] r);
		logic [15:0] n;
		n = r >> 1;
		if (r[0])
			n = n ^ NOISE_TAPS;
		return n;
	endfunction

endpackage

// ----- rtl/twg_regs.sv -----
// configuration register file with an apb-style port
`timescale 1ns / 1ps

module twg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [twg_pkg::ADDR_W-1:0]  paddr,
	input  logic [twg_pkg::DATA_W-1:0]  pwdata,
	output logic [twg_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output twg_pkg::cfg_t               cfg
);

	twg_pkg::cfg_t              cfg_q;
	logic [twg_pkg::REG_W-1:0]  reg_sel;
	logic                       wr_en;

	assign reg_sel = paddr[twg_pkg::ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable       <= 1'b0;
			cfg_q.phase_step   <= twg_pkg::PHASE_STEP_RST;
			cfg_q.wave_kind    <= twg_pkg::WAVE_SINE;
			cfg_q.tone_level   <= twg_pkg::TONE_LEVEL_RST;
			cfg_q.master_level <= twg_pkg::MASTER_LEVEL_RST;
			cfg_q.tone_length  <= twg_pkg::TONE_LENGTH_RST;
			cfg_q.fade_length  <= twg_pkg::FADE_LENGTH_RST;
		end else if (wr_en) begin
			case (reg_sel)
				twg_pkg::REG_ENABLE:       cfg_q.enable       <= pwdata[0];
				twg_pkg::REG_PHASE_STEP:   cfg_q.phase_step   <= pwdata;
				twg_pkg::REG_WAVE_KIND:    cfg_q.wave_kind    <= pwdata[1:0];
				twg_pkg::REG_TONE_LEVEL:   cfg_q.tone_level   <= pwdata[twg_pkg::LEVEL_W-1:0];
				twg_pkg::REG_MASTER_LEVEL: cfg_q.master_level <= pwdata[twg_pkg::LEVEL_W-1:0];
				twg_pkg::REG_TONE_LENGTH:  cfg_q.tone_length  <= pwdata[twg_pkg::TONE_LEN_W-1:0];
				twg_pkg::REG_FADE_LENGTH:  cfg_q.fade_length  <= pwdata[twg_pkg::FADE_W-1:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (reg_sel)
			twg_pkg::REG_ENABLE:       prdata = 32'(cfg_q.enable);
			twg_pkg::REG_PHASE_STEP:   prdata = cfg_q.phase_step;
			twg_pkg::REG_WAVE_KIND:    prdata = 32'(cfg_q.wave_kind);
			twg_pkg::REG_TONE_LEVEL:   prdata = 32'(cfg_q.tone_level);
			twg_pkg::REG_MASTER_LEVEL: prdata = 32'(cfg_q.master_level);
			twg_pkg::REG_TONE_LENGTH:  prdata = 32'(cfg_q.tone_length);
			twg_pkg::REG_FADE_LENGTH:  prdata = 32'(cfg_q.fade_length);
			default:                   prdata = '0;
		endcase
	end

endmodule

// ----- rtl/twg_wave.sv -----
// waveform select: sine table, square, sawtooth and noise as sign and magnitude
`timescale 1ns / 1ps

module twg_wave #(
	parameter int SINE_TABLE_BITS = twg_pkg::SINE_TABLE_BITS_DEF
) (
	input  logic [31:0]               phase,
	input  logic [15:0]               noise,
	input  logic [1:0]                wave_kind,
	output logic [twg_pkg::MAG_W-1:0] mag,
	output logic                      neg
);

	localparam int AW      = SINE_TABLE_BITS - 1;
	localparam int QUARTER = 1 << (SINE_TABLE_BITS - 2);
	localparam logic [AW-1:0] QUARTER_IDX = AW'(QUARTER);

	logic [twg_pkg::MAG_W-1:0] sine_rom [0:QUARTER];
	logic [SINE_TABLE_BITS-1:0] idx;
	logic [1:0]                 quad;
	logic [AW-1:0]              rom_addr;
	logic [twg_pkg::MAG_W-1:0]  sine_mag;
	logic                       sine_neg;
	logic [twg_pkg::MAG_W-1:0]  saw_mag;
	logic                       saw_neg;
	logic [twg_pkg::MAG_W-1:0]  noise_mag;
	logic                       noise_neg;

	// quarter-wave table, values fixed at elaboration
	for (genvar k = 0; k <= QUARTER; k++) begin : g_rom
		localparam logic [twg_pkg::MAG_W-1:0] ENTRY = twg_pkg::quarter_sine(k, SINE_TABLE_BITS);
		assign sine_rom[k] = ENTRY;
	end

	// mirror the quarter wave by quadrant
	assign idx      = phase[31 -: SINE_TABLE_BITS];
	assign quad     = idx[SINE_TABLE_BITS-1 -: 2];
	assign rom_addr = quad[0] ? QUARTER_IDX - {1'b0, idx[SINE_TABLE_BITS-3:0]}
	                          : {1'b0, idx[SINE_TABLE_BITS-3:0]};
	assign sine_mag = sine_rom[rom_addr];
	assign sine_neg = quad[1] && (sine_mag != '0);

	// offset binary to sign and magnitude, bottom code saturates
	function automatic logic [twg_pkg::MAG_W:0] offset_to_sm(input logic [15:0] v);
		logic [twg_pkg::MAG_W-1:0] m;
		if (v[15])
			return {1'b0, v[14:0]};
		m = (v[14:0] == '0) ? twg_pkg::FULL_SCALE : 15'(-v[14:0]);
		return {1'b1, m};
	endfunction

	assign {saw_neg, saw_mag}     = offset_to_sm(phase[31:16]);
	assign {noise_neg, noise_mag} = offset_to_sm(noise);

	// waveform select
	always_comb begin
		case (wave_kind)
			twg_pkg::WAVE_SINE: begin
				mag = sine_mag;
				neg = sine_neg;
			end
			twg_pkg::WAVE_SQUARE: begin
				mag = twg_pkg::FULL_SCALE;
				neg = sine_neg;
			end
			twg_pkg::WAVE_SAW: begin
				mag = saw_mag;
				neg = saw_neg;
			end
			default: begin
				mag = noise_mag;
				neg = noise_neg;
			end
		endcase
	end

endmodule

// ----- rtl/twg_mdu.sv -----
// shared arithmetic unit: one 32x17 multiplier and one restoring divide step
`timescale 1ns / 1ps

module twg_mdu (
	input  twg_pkg::mdu_in_t  req,
	output twg_pkg::mdu_out_t rsp
);

	logic [16:0] trial;
	logic        fits;
	logic [16:0] diff;

	// multiply
	assign rsp.prod = 49'(req.mul_a) * 49'(req.mul_b);

	// one quotient bit: shift in the next dividend bit, subtract if it fits
	assign trial    = {req.rem, req.dbit};
	assign fits     = trial >= {1'b0, req.den};
	assign diff     = trial - {1'b0, req.den};
	assign rsp.qbit = fits;
	assign rsp.rem  = fits ? diff[15:0] : trial[15:0];

endmodule

// ----- rtl/tone_waveform_generator_core.sv -----
// tone generator top level: sample sequencer, state and output register
//
// one input beat on (in_valid, in_ready, start_req) is one sample tick.
// start_req = 1 restarts the tone (phase and sample index cleared, noise
// register reseeded) and produces sample 0; start_req = 0 produces the next sample.
// a tick that makes a sample gives one output beat (out_valid, out_ready,
// sample, last); last marks the final sample of the tone. ticks past the
// end, with the block disabled or at zero level give no beat.
// configuration goes through the apb port, registers at byte address 4*i.
// a producing tick runs through the states wave (wave lookup, envelope and
// the first of three multiplier passes), mul1 and mul2 (two more passes),
// div (one-bit restoring division in the same unit) and out (output step).
// a new tick is taken only once the sequencer is back in idle, not while a
// sample is in work; a tick without a sample leaves the sequencer in idle.
// in_ready stays high in idle even while a finished beat waits on out_ready;
// if the output register is still full when the next sample is done, the
// sequencer holds in its output step until the receiver takes the beat.
// reset returns the tone state to its start values, empties the output register and loads the
// register defaults; the block is ready right after reset.
`timescale 1ns / 1ps

module tone_waveform_generator_core #(
	parameter int SINE_TABLE_BITS = twg_pkg::SINE_TABLE_BITS_DEF,
	parameter int INDEX_BITS      = twg_pkg::INDEX_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [twg_pkg::ADDR_W-1:0]  paddr,
	input  logic [twg_pkg::DATA_W-1:0]  pwdata,
	output logic [twg_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        start_req,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [15:0]          sample,
	output logic                        last
);

	localparam int LW = ((INDEX_BITS > twg_pkg::TONE_LEN_W) ? INDEX_BITS
	                                                        : twg_pkg::TONE_LEN_W) + 1;
	localparam logic [LW-1:0] IDX_LIMIT = LW'(1) << INDEX_BITS;
	localparam int CNT_W = $clog2(twg_pkg::DIV_STEPS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(twg_pkg::DIV_STEPS - 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_WAVE = 3'd1;
	localparam logic [2:0] ST_MUL1 = 3'd2;
	localparam logic [2:0] ST_MUL2 = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	twg_pkg::cfg_t      cfg;
	twg_pkg::mdu_in_t   mdu_req;
	twg_pkg::mdu_out_t  mdu_rsp;

	logic [2:0]                state_q;
	logic [31:0]               phase_q;
	logic [INDEX_BITS-1:0]     idx_q;
	logic [15:0]               noise_q;
	logic                      active_q;
	logic [twg_pkg::MAG_W-1:0] wave_mag_q;
	logic                      wave_neg_q;
	logic [15:0]               env_e_q;
	logic [15:0]               env_f_q;
	logic [31:0]               acc_q;
	logic [15:0]               rem_q;
	logic [15:0]               quo_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      out_valid_q;
	logic signed [15:0]        sample_q;
	logic                      last_q;

	logic                      accept;
	logic [LW-1:0]             len_ext;
	logic [LW-1:0]             len;
	logic [LW-1:0]             idx_ext;
	logic                      vol_nz;
	logic [twg_pkg::LEVEL_W-1:0] tl_c;
	logic [twg_pkg::LEVEL_W-1:0] ml_c;
	logic [31:0]               phase_n;
	logic [INDEX_BITS-1:0]     idx_n;
	logic [15:0]               noise_n;
	logic                      active_n;
	logic                      in_range_n;
	logic                      go;
	logic [twg_pkg::MAG_W-1:0] wave_mag;
	logic                      wave_neg;
	logic [15:0]               env_e;
	logic [15:0]               env_f;
	logic                      is_last;
	logic                      out_load;

	twg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	twg_wave #(
		.SINE_TABLE_BITS (SINE_TABLE_BITS)
	) u_wave (
		.phase     (phase_q),
		.noise     (noise_q),
		.wave_kind (cfg.wave_kind),
		.mag       (wave_mag),
		.neg       (wave_neg)
	);

	twg_mdu u_mdu (
		.req (mdu_req),
		.rsp (mdu_rsp)
	);

	// effective length, levels clamped to full scale
	assign len_ext = LW'(cfg.tone_length);
	assign len     = (len_ext > IDX_LIMIT) ? IDX_LIMIT : len_ext;
	assign idx_ext = LW'(idx_q);
	assign tl_c    = (cfg.tone_level > twg_pkg::FULL_LEVEL) ? twg_pkg::FULL_LEVEL
	                                                        : cfg.tone_level;
	assign ml_c    = (cfg.master_level > twg_pkg::FULL_LEVEL) ? twg_pkg::FULL_LEVEL
	                                                          : cfg.master_level;
	assign vol_nz  = (cfg.tone_level != '0) && (cfg.master_level != '0);

	// tick decision at accept
	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign phase_n    = start_req ? '0 : phase_q;
	assign idx_n      = start_req ? '0 : idx_q;
	assign noise_n    = start_req ? twg_pkg::NOISE_SEED : noise_q;
	assign active_n   = start_req ? (cfg.enable && vol_nz && (len != '0)) : active_q;
	assign in_range_n = LW'(idx_n) < len;
	assign go         = active_n && cfg.enable && vol_nz && in_range_n;

	// fade envelope numerator and denominator
	always_comb begin
		if (cfg.fade_length == '0) begin
			env_e = 16'd1;
			env_f = 16'd1;
		end else if (idx_ext < LW'(cfg.fade_length)) begin
			env_e = idx_ext[15:0];
			env_f = cfg.fade_length;
		end else if (idx_ext + LW'(cfg.fade_length) > len) begin
			env_e = 16'(len - idx_ext);
			env_f = cfg.fade_length;
		end else begin
			env_e = cfg.fade_length;
			env_f = cfg.fade_length;
		end
	end

	assign is_last  = (idx_ext + LW'(1)) == len;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	// operand select for the shared unit
	always_comb begin
		mdu_req.rem  = rem_q;
		mdu_req.dbit = quo_q[15];
		mdu_req.den  = env_f_q;
		case (state_q)
			ST_WAVE: begin
				mdu_req.mul_a = 32'(tl_c);
				mdu_req.mul_b = 17'(ml_c);
			end
			ST_MUL1: begin
				mdu_req.mul_a = acc_q;
				mdu_req.mul_b = 17'(wave_mag_q);
			end
			default: begin
				mdu_req.mul_a = acc_q;
				mdu_req.mul_b = 17'(env_e_q);
			end
		endcase
	end

	// sequencer and tone state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			phase_q  <= '0;
			idx_q    <= '0;
			noise_q  <= twg_pkg::NOISE_SEED;
			active_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						phase_q  <= phase_n;
						idx_q    <= idx_n;
						noise_q  <= go ? twg_pkg::noise_step(noise_n) : noise_n;
						active_q <= active_n && (in_range_n || !cfg.enable || !vol_nz);
						if (go)
							state_q <= ST_WAVE;
					end
				end
				ST_WAVE: state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST)
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						idx_q   <= INDEX_BITS'(idx_q + 1'b1);
						phase_q <= phase_q + cfg.phase_step;
						if (is_last)
							active_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_WAVE: begin
				wave_mag_q <= wave_mag;
				wave_neg_q <= wave_neg;
				env_e_q    <= env_e;
				env_f_q    <= env_f;
				acc_q      <= mdu_rsp.prod[31:0];
			end
			ST_MUL1: acc_q <= mdu_rsp.prod[31:0];
			// drop the low 16 bits: dividend is the product over 65536
			ST_MUL2: begin
				rem_q <= mdu_rsp.prod[47:32];
				quo_q <= mdu_rsp.prod[31:16];
			end
			ST_DIV: begin
				rem_q <= mdu_rsp.rem;
				quo_q <= {quo_q[14:0], mdu_rsp.qbit};
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			sample_q <= wave_neg_q ? $signed(16'(-quo_q)) : $signed(quo_q);
			last_q   <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign sample    = sample_q;
	assign last      = last_q;

endmodule

// ----- rtl/twg_checker.sv -----
// port-level checker for the tone generator, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module twg_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] sample,
	input logic               last
);

	// a stalled beat keeps its payload
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(sample) && $stable(last))

	// samples stay symmetric, the most negative code never shows
	`ASSERT_IMPLY(a_no_min_code, clk, arst_n, out_valid, sample != 16'sh8000)

	// a new beat only comes out of a busy tick
	`ASSERT_IMPLY(a_out_after_busy, clk, arst_n, $rose(out_valid), $past(!in_ready))

	// the block only goes busy on an accepted tick
	`ASSERT_IMPLY(a_busy_after_accept, clk, arst_n, $fell(in_ready), $past(in_valid))

endmodule

bind tone_waveform_generator_core twg_checker u_twg_checker (.*);

// ----- test/tone_waveform_generator_checker.sv -----
// checker for the tone generator: watches register writes, ticks and samples, predicts each sample and compares
`timescale 1ns / 1ps

module tone_waveform_generator_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic                       pready,
	input  logic [twg_pkg::ADDR_W-1:0] paddr,
	input  logic [twg_pkg::DATA_W-1:0] pwdata,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic                       start_req,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic signed [15:0]         sample,
	input  logic                       last,
	output int                         fail_count,
	output int                         pending
);
	import twg_pkg::*;

	localparam int              ROM_BITS         = 10;
	localparam int              IDX_BITS         = 20;
	localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
	localparam int              MAX_MAG          = 32767;

	typedef struct {
		logic signed [15:0] sample;
		logic               last;
	} tone_beat_t;

	// register copy and tone state
	cfg_t                regs;
	logic [31:0]         ph;
	logic [IDX_BITS-1:0] pos;
	logic [15:0]         lfsr;
	logic                playing;

	tone_beat_t  want_beats [$];
	tone_beat_t  head;
	int          errs;
	int unsigned quarter_rom [0:(1 << (ROM_BITS - 2))];

	// first quarter of the sine, q30 taylor series to degree 13, rounded to q15
	function automatic int unsigned quarter_mag(input int unsigned r);
		longint unsigned ang;
		longint unsigned ang_sq;
		longint unsigned term;
		longint unsigned mag;
		longint          acc;
		ang = (QUARTER_TURN_Q30 * 64'(r)) >> (ROM_BITS - 2);
		ang_sq = (ang * ang) >> 30;
		term = ang;
		acc = longint'(ang);
		for (int n = 1; n <= 6; n++) begin
			term = ((term * ang_sq) >> 30) / 64'((2 * n) * (2 * n + 1));
			if (n % 2 == 1)
				acc = acc - longint'(term);
			else
				acc = acc + longint'(term);
		end
		if (acc < 0)
			acc = 0;
		mag = (64'(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
		if (mag > 64'd32767)
			mag = 64'd32767;
		return mag[31:0];
	endfunction

	initial begin
		for (int r = 0; r <= (1 << (ROM_BITS - 2)); r++)
			quarter_rom[r] = quarter_mag(r);
	end

	// full wave from the quarter table, top phase bits select the slot
	function automatic int sine_at(input logic [31:0] p);
		logic [ROM_BITS-1:0] slot;
		int                  mag;
		slot = p[31 -: ROM_BITS];
		if (slot[ROM_BITS-2])
			mag = quarter_rom[(1 << (ROM_BITS - 2)) - slot[ROM_BITS-3:0]];
		else
			mag = quarter_rom[slot[ROM_BITS-3:0]];
		return slot[ROM_BITS-1] ? -mag : mag;
	endfunction

	// advance the tone by one tick, queue the sample it makes
	task automatic tone_tick(input logic restart);
		longint unsigned tl;
		longint unsigned ml;
		longint unsigned vol;
		longint unsigned len;
		longint unsigned i;
		longint unsigned f;
		longint unsigned e;
		longint unsigned mag;
		longint unsigned res;
		longint          s;
		int              w;
		logic            lsb;
		logic            fin;
		tone_beat_t      beat;
		tl = (regs.tone_level > FULL_LEVEL) ? 64'd256 : 64'(regs.tone_level);
		ml = (regs.master_level > FULL_LEVEL) ? 64'd256 : 64'(regs.master_level);
		vol = tl * ml;
		len = 64'(regs.tone_length);

		if (restart) begin
			ph = '0;
			pos = '0;
			lfsr = NOISE_SEED;
			playing = regs.enable && (vol != 0) && (len != 0);
		end
		if (!playing || !regs.enable || vol == 0)
			return;
		i = 64'(pos);
		// length cut below the current index ends the tone silently
		if (i >= len) begin
			playing = 1'b0;
			return;
		end

		// noise register steps on every produced sample
		lsb = lfsr[0];
		lfsr = lfsr >> 1;
		if (lsb)
			lfsr = lfsr ^ NOISE_TAPS;

		case (regs.wave_kind)
			WAVE_SINE:   w = sine_at(ph);
			WAVE_SQUARE: w = (sine_at(ph) >= 0) ? MAX_MAG : -MAX_MAG;
			WAVE_SAW:    w = int'(ph[31:16]) - 32768;
			default:     w = int'(lfsr) - 32768;
		endcase
		if (w < -MAX_MAG)
			w = -MAX_MAG;

		// linear fade envelope, zero fade means flat
		f = 64'(regs.fade_length);
		if (f == 0) begin
			e = 1;
			f = 1;
		end else if (i < f) begin
			e = i;
		end else if (i + f > len) begin
			e = len - i;
		end else begin
			e = f;
		end

		mag = (w < 0) ? 64'(-w) : 64'(w);
		res = (mag * vol * e) / (64'd65536 * f);
		if (res > 64'd32767)
			res = 64'd32767;
		s = (w < 0) ? -longint'(res) : longint'(res);

		fin = (i + 1 == len);
		beat.sample = s[15:0];
		beat.last = fin;
		want_beats.push_back(beat);

		pos = pos + 1'b1;
		ph = ph + regs.phase_step;
		if (fin)
			playing = 1'b0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.enable = 1'b0;
			regs.phase_step = PHASE_STEP_RST;
			regs.wave_kind = WAVE_SINE;
			regs.tone_level = TONE_LEVEL_RST;
			regs.master_level = MASTER_LEVEL_RST;
			regs.tone_length = TONE_LENGTH_RST;
			regs.fade_length = FADE_LENGTH_RST;
			ph = '0;
			pos = '0;
			lfsr = NOISE_SEED;
			playing = 1'b0;
			want_beats.delete();
			errs = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			// register writes
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_ENABLE:       regs.enable = pwdata[0];
					REG_PHASE_STEP:   regs.phase_step = pwdata;
					REG_WAVE_KIND:    regs.wave_kind = pwdata[1:0];
					REG_TONE_LEVEL:   regs.tone_level = pwdata[LEVEL_W-1:0];
					REG_MASTER_LEVEL: regs.master_level = pwdata[LEVEL_W-1:0];
					REG_TONE_LENGTH:  regs.tone_length = pwdata[TONE_LEN_W-1:0];
					REG_FADE_LENGTH:  regs.fade_length = pwdata[FADE_W-1:0];
					default: ;
				endcase
			end

			// input tick
			if (in_valid && in_ready)
				tone_tick(start_req);

			// output beat against the oldest expected sample
			if (out_valid && out_ready) begin
				if (want_beats.size() == 0) begin
					$error("unexpected sample beat: sample %0d last %0b", sample, last);
					errs++;
				end else begin
					head = want_beats.pop_front();
					if (sample !== head.sample) begin
						$error("sample mismatch: expected %0d, actual %0d", head.sample, sample);
						errs++;
					end
					if (last !== head.last) begin
						$error("last mismatch: expected %0b, actual %0b", head.last, last);
						errs++;
					end
				end
			end

			fail_count <= errs;
			pending <= want_beats.size();
		end
	end

endmodule

// ----- test/tb_tone_waveform_generator_core.sv -----
// testbench top for the tone generator: clock, reset, stimulus, stalls and verdict
`timescale 1ns / 1ps

module tb_tone_waveform_generator_core;
	import twg_pkg::*;

	localparam int RANDOM_TICKS   = 500;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 32;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                psel      = 1'b0;
	logic                penable   = 1'b0;
	logic                pwrite    = 1'b0;
	logic [ADDR_W-1:0]   paddr     = '0;
	logic [DATA_W-1:0]   pwdata    = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                in_valid  = 1'b0;
	logic                in_ready;
	logic                start_req = 1'b0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic signed [15:0]  sample;
	logic                last;

	int fail_count;
	int pending;
	int burst_left   = 0;
	int ready_hold   = 0;
	int idle_cycles  = 0;
	int sample_ticks = 0;

	// what the stimulus last wrote, to know which ticks can make samples
	logic sh_en  = 1'b0;
	int   sh_tl  = 77;
	int   sh_ml  = 256;
	int   sh_len = 2205;

	always #6 clk = ~clk;

	tone_waveform_generator_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.start_req (start_req),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sample    (sample),
		.last      (last)
	);

	tone_waveform_generator_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.start_req  (start_req),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample     (sample),
		.last       (last),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// receiver stalls: long ready runs, long stalls and single random cycles
	always @(posedge clk) begin
		if (ready_hold != 0) begin
			ready_hold <= ready_hold - 1;
		end else begin
			case ($urandom_range(0, 3))
				0: begin
					out_ready <= 1'b1;
					ready_hold <= $urandom_range(0, 30);
				end
				1: begin
					out_ready <= 1'b0;
					ready_hold <= $urandom_range(0, 40);
				end
				default: begin
					out_ready <= 1'($urandom_range(0, 1));
					ready_hold <= 0;
				end
			endcase
		end
	end

	// watchdog on cycles with no beat and no register write
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("** tone_waveform_generator_core: FAILED **");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// register write: setup phase, access phase, then an idle phase
	task automatic cfg_write(input logic [REG_W-1:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_ENABLE:       sh_en = val[0];
			REG_TONE_LEVEL:   sh_tl = int'(val[LEVEL_W-1:0]);
			REG_MASTER_LEVEL: sh_ml = int'(val[LEVEL_W-1:0]);
			REG_TONE_LENGTH:  sh_len = int'(val[TONE_LEN_W-1:0]);
			default: ;
		endcase
	endtask

	// one tick beat, sent in bursts with random gaps between them
	task automatic send_tick(input logic restart);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b1;
		start_req <= restart;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		burst_left--;
	endtask

	// wait until every expected sample is out and the block is quiet
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_level();
		case ($urandom_range(0, 9))
			0:       return 32'd0;
			1:       return $urandom_range(257, 511);
			2:       return 32'd256;
			default: return $urandom_range(1, 256);
		endcase
	endfunction

	initial begin
		int          n_tones;
		int          k;
		logic [31:0] val;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// start and plain tick while disabled: nothing comes out
		send_tick(1'b1);
		send_tick(1'b0);
		settle();

		// quarter-turn sine at clamped full level, no fade, one tick past the end
		cfg_write(REG_ENABLE, 32'd1);
		cfg_write(REG_PHASE_STEP, 32'h4000_0000);
		cfg_write(REG_WAVE_KIND, 32'(WAVE_SINE));
		cfg_write(REG_TONE_LEVEL, 32'd300);
		cfg_write(REG_MASTER_LEVEL, 32'd256);
		cfg_write(REG_TONE_LENGTH, 32'd6);
		cfg_write(REG_FADE_LENGTH, 32'd0);
		send_tick(1'b1);
		repeat (6) send_tick(1'b0);
		settle();

		// square with the largest step and a short fade
		cfg_write(REG_WAVE_KIND, 32'(WAVE_SQUARE));
		cfg_write(REG_PHASE_STEP, 32'hFFFF_FFFF);
		cfg_write(REG_TONE_LENGTH, 32'd3);
		cfg_write(REG_FADE_LENGTH, 32'd2);
		send_tick(1'b1);
		repeat (2) send_tick(1'b0);
		settle();

		// sawtooth: start at zero level stays idle
		cfg_write(REG_WAVE_KIND, 32'(WAVE_SAW));
		cfg_write(REG_TONE_LEVEL, 32'd0);
		send_tick(1'b1);
		settle();

		// master level clamped, longest fade, then length cut below the index
		cfg_write(REG_TONE_LEVEL, 32'd256);
		cfg_write(REG_MASTER_LEVEL, 32'd511);
		cfg_write(REG_TONE_LENGTH, 32'd4);
		cfg_write(REG_FADE_LENGTH, 32'd65535);
		send_tick(1'b1);
		send_tick(1'b0);
		settle();
		cfg_write(REG_TONE_LENGTH, 32'd1);
		send_tick(1'b0);
		send_tick(1'b0);
		settle();

		// noise tone, disabled in the middle with state held
		cfg_write(REG_WAVE_KIND, 32'(WAVE_NOISE));
		cfg_write(REG_PHASE_STEP, $urandom());
		cfg_write(REG_TONE_LENGTH, 32'd4);
		cfg_write(REG_FADE_LENGTH, 32'd1);
		send_tick(1'b1);
		send_tick(1'b0);
		settle();
		cfg_write(REG_ENABLE, 32'd0);
		send_tick(1'b0);
		settle();
		cfg_write(REG_ENABLE, 32'd1);
		send_tick(1'b0);
		send_tick(1'b0);
		settle();

		// zero length start stays idle
		cfg_write(REG_TONE_LENGTH, 32'd0);
		send_tick(1'b1);

		// random phases: new settings, then mostly whole tones
		while (sample_ticks < RANDOM_TICKS) begin
			settle();
			if ($urandom_range(0, 3) != 0)
				cfg_write(REG_ENABLE, ($urandom_range(0, 9) != 0) ? 32'd1 : 32'd0);
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 5))
					0:       val = 32'd0;
					1:       val = 32'hFFFF_FFFF;
					2:       val = $urandom_range(0, 1 << 20);
					default: val = $urandom();
				endcase
				cfg_write(REG_PHASE_STEP, val);
			end
			if ($urandom_range(0, 3) != 0)
				cfg_write(REG_WAVE_KIND, $urandom_range(0, 3));
			if ($urandom_range(0, 3) != 0)
				cfg_write(REG_TONE_LEVEL, pick_level());
			if ($urandom_range(0, 3) != 0)
				cfg_write(REG_MASTER_LEVEL, pick_level());
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 19))
					0:       val = $urandom_range(0, 20'hFFFFF);
					1:       val = 32'h000F_FFFF;
					2:       val = 32'd0;
					3:       val = 32'd1;
					default: val = $urandom_range(2, 40);
				endcase
				cfg_write(REG_TONE_LENGTH, val);
			end
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 9))
					0:       val = 32'd0;
					1:       val = $urandom_range(0, 65535);
					2:       val = 32'd65535;
					default: val = $urandom_range(1, 24);
				endcase
				cfg_write(REG_FADE_LENGTH, val);
			end

			// ticks into whatever tone is still running under the new settings
			if ($urandom_range(0, 5) == 0)
				repeat ($urandom_range(1, 4)) send_tick(1'b0);

			n_tones = $urandom_range(1, 3);
			repeat (n_tones) begin
				if (!sh_en || sh_tl == 0 || sh_ml == 0 || sh_len == 0) begin
					send_tick(1'b1);
					send_tick(1'b0);
				end else if ($urandom_range(0, 7) == 0) begin
					// broken sequence: restarts at random points
					repeat ($urandom_range(1, 12)) send_tick($urandom_range(0, 3) == 0);
				end else begin
					k = (sh_len > 60) ? $urandom_range(0, 60) : sh_len - 1 + $urandom_range(0, 2);
					send_tick(1'b1);
					repeat (k) send_tick(1'b0);
					sample_ticks += 1 + ((k < sh_len) ? k : sh_len - 1);
				end
			end
		end

		settle();
		if (fail_count == 0)
			$display("** tone_waveform_generator_core: PASSED **");
		else
			$display("** tone_waveform_generator_core: FAILED **");
		$finish;
	end

endmodule
